// File: hw/rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared widths, controller states, command/status structs and the
// leading-zero count used by the Morton split finder.
// ----------------------------------------------------------------------------
`default_nettype none

package msf_pkg;

  // Table geometry and field widths
  localparam int MAX_ENTRIES = 1024;
  localparam int CODE_BITS   = 32;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int IDX_W       = 10;
  localparam int VAL_W       = 32;
  localparam int CLZ_W       = $clog2(CODE_BITS + 1);

  localparam logic [IDX_W:0] ENTRY_LIM = (IDX_W + 1)'(MAX_ENTRIES);

  // Function codes of an input word
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [CLZ_W-1:0]     clz_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_SETUP,
    ST_STEP,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_en;     // store the code of the input word
    logic q_load;    // latch the range, read the first code
    logic fc_load;   // latch the first code, read the last code
    logic setup;     // compare ends, seed the search
    logic step_en;   // test one probe, issue the next
    logic out_load;  // move the split into the output register
    logic out_err;   // load an inverted-range result from the input word
  } msf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register empty or being taken
    logic inverted;    // input word has first above last
    logic ends_equal;  // codes at both ends match
    logic step_more;   // search step still above one
  } msf_stat_t;

  // Leading zeros of v; zero gives CODE_BITS
  function automatic clz_t lead_zeros(input code_t v);
    clz_t n;
    n = clz_t'(CODE_BITS);
    for (int i = 0; i < CODE_BITS; i++) begin
      if (v[i]) begin
        n = clz_t'(CODE_BITS - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/msf_if.sv
// ----------------------------------------------------------------------------
// msf_req_if / msf_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface msf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [msf_pkg::IDX_W-1:0]  slot;
  logic [msf_pkg::VAL_W-1:0]  code_value;
  logic [msf_pkg::IDX_W-1:0]  range_first;
  logic [msf_pkg::IDX_W-1:0]  range_last;

  modport source (output valid, func, slot, code_value, range_first, range_last,
                  input ready);
  modport sink   (input valid, func, slot, code_value, range_first, range_last,
                  output ready);
endinterface

interface msf_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [msf_pkg::IDX_W-1:0]  split_index;
  logic                       range_error;

  modport source (output valid, split_index, range_error, input ready);
  modport sink   (input valid, split_index, range_error, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/msf_ctrl.sv
// ----------------------------------------------------------------------------
// msf_ctrl
// Sequencer for the split search: accepts words, walks the read, setup and
// search steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_func,
  output logic                    in_ready,
  input  wire msf_pkg::msf_stat_t stat,
  output msf_pkg::msf_cmd_t       cmd
);

  msf_pkg::state_t state, state_next;
  logic            accept;

  assign in_ready = (state == msf_pkg::ST_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      msf_pkg::ST_IDLE: begin
        if (accept && (in_func == msf_pkg::FUNC_QUERY) && !stat.inverted) begin
          state_next = msf_pkg::ST_RD_LAST;
        end
      end
      msf_pkg::ST_RD_LAST: state_next = msf_pkg::ST_SETUP;
      msf_pkg::ST_SETUP: begin
        state_next = stat.ends_equal ? msf_pkg::ST_DONE : msf_pkg::ST_STEP;
      end
      msf_pkg::ST_STEP: begin
        if (!stat.step_more) begin
          state_next = msf_pkg::ST_DONE;
        end
      end
      msf_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_next = msf_pkg::ST_IDLE;
        end
      end
      default: state_next = msf_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      msf_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == msf_pkg::FUNC_WRITE) begin
            cmd.wr_en = 1'b1;
          end else if (stat.inverted) begin
            cmd.out_err = 1'b1;
          end else begin
            cmd.q_load = 1'b1;
          end
        end
      end
      msf_pkg::ST_RD_LAST: cmd.fc_load  = 1'b1;
      msf_pkg::ST_SETUP:   cmd.setup    = 1'b1;
      msf_pkg::ST_STEP:    cmd.step_en  = 1'b1;
      msf_pkg::ST_DONE:    cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/msf_dpath.sv
// ----------------------------------------------------------------------------
// msf_dpath
// Code table, range and search registers, leading-zero compare and the
// output register of the split finder.
// ----------------------------------------------------------------------------
`default_nettype none

module msf_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire msf_pkg::msf_cmd_t          cmd,
  output msf_pkg::msf_stat_t              stat,
  input  wire logic [msf_pkg::IDX_W-1:0]  slot,
  input  wire logic [msf_pkg::VAL_W-1:0]  code_value,
  input  wire logic [msf_pkg::IDX_W-1:0]  range_first,
  input  wire logic [msf_pkg::IDX_W-1:0]  range_last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [msf_pkg::IDX_W-1:0]       split_index,
  output logic                            range_error
);

  localparam int IW = msf_pkg::IDX_W;

  msf_pkg::code_t             mem [msf_pkg::MAX_ENTRIES];
  msf_pkg::code_t             rd_data;
  logic [msf_pkg::ADDR_W-1:0] rd_addr;

  msf_pkg::code_t fc;
  logic [IW-1:0]  first_r;
  logic [IW-1:0]  last_r;
  logic [IW-1:0]  split;
  logic [IW-1:0]  step;
  logic [IW:0]    probe;
  msf_pkg::clz_t  prefix;

  logic [IW:0]    span_sum;
  logic [IW-1:0]  step0;
  logic [IW-1:0]  step1;
  logic [IW-1:0]  step_n;
  logic           hit;
  logic [IW-1:0]  split_new;
  logic [IW:0]    probe_seed;
  logic [IW:0]    probe_next;

  // Search arithmetic
  always_comb begin
    span_sum   = {1'b0, first_r} + {1'b0, last_r};
    step0      = last_r - first_r;
    step1      = IW'(({1'b0, step0} + (IW + 1)'(1)) >> 1);
    step_n     = IW'(({1'b0, step} + (IW + 1)'(1)) >> 1);
    probe_seed = {1'b0, first_r} + {1'b0, step1};
    hit        = (probe < {1'b0, last_r}) &&
                 (msf_pkg::lead_zeros(fc ^ rd_data) > prefix);
    split_new  = hit ? probe[IW-1:0] : split;
    probe_next = {1'b0, split_new} + {1'b0, step_n};
  end

  // Status
  always_comb begin
    stat.out_free   = !out_valid || out_ready;
    stat.inverted   = range_first > range_last;
    stat.ends_equal = (fc == rd_data);
    stat.step_more  = step > IW'(1);
  end

  // Read address select
  always_comb begin
    priority if (cmd.q_load) begin
      rd_addr = range_first[msf_pkg::ADDR_W-1:0];
    end else if (cmd.fc_load) begin
      rd_addr = last_r[msf_pkg::ADDR_W-1:0];
    end else if (cmd.setup) begin
      rd_addr = probe_seed[msf_pkg::ADDR_W-1:0];
    end else begin
      rd_addr = probe_next[msf_pkg::ADDR_W-1:0];
    end
  end

  // Code table: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && ({1'b0, slot} < msf_pkg::ENTRY_LIM)) begin
      mem[slot[msf_pkg::ADDR_W-1:0]] <= code_value[msf_pkg::CODE_BITS-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  // Range and search registers
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      first_r <= range_first;
      last_r  <= range_last;
    end
    if (cmd.fc_load) begin
      fc <= rd_data;
    end
    if (cmd.setup) begin
      if (fc == rd_data) begin
        split <= span_sum[IW:1];
      end else begin
        prefix <= msf_pkg::lead_zeros(fc ^ rd_data);
        split  <= first_r;
        step   <= step1;
        probe  <= probe_seed;
      end
    end
    if (cmd.step_en) begin
      split <= split_new;
      step  <= step_n;
      probe <= probe_next;
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load || cmd.out_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_err) begin
      split_index <= range_first;
      range_error <= 1'b1;
    end else if (cmd.out_load) begin
      split_index <= split;
      range_error <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/morton_split_finder.sv
// ----------------------------------------------------------------------------
// morton_split_finder
// Table of sorted Morton codes with a binary-search split finder.
//
//   channel | dir | words
//   req     | in  | func 0: store code_value at slot; func 1: query range
//   rsp     | out | split_index, range_error; one per query, none per store
//
// A store writes code_value into the table. A query with first above last is
// answered from the input word with range_error set. Any other query reads
// the first and last codes through the single read port of the code table,
// then, unless the end codes match, searches with one probe per cycle. Reset
// (rst, synchronous) clears the controller and the output valid only; the
// table holds nothing defined until written. A stalled rsp holds its word;
// req waits while a result is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module morton_split_finder (
  input  wire logic clk,
  input  wire logic rst,
  msf_req_if.sink   req,
  msf_rsp_if.source rsp
);

  msf_pkg::msf_cmd_t  cmd;
  msf_pkg::msf_stat_t stat;
  logic               in_ready;
  logic               out_valid;
  logic [msf_pkg::IDX_W-1:0] split_index;
  logic               range_error;

  // Controller
  msf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_func  (req.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  msf_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .slot        (req.slot),
    .code_value  (req.code_value),
    .range_first (req.range_first),
    .range_last  (req.range_last),
    .out_valid   (out_valid),
    .out_ready   (rsp.ready),
    .split_index (split_index),
    .range_error (range_error)
  );

  assign req.ready       = in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.split_index = split_index;
  assign rsp.range_error = range_error;

endmodule

`default_nettype wire
